// ===== src/streaming_viterbi_decoder_defines.svh =====
// Assertion helpers for the Viterbi decoder.
`ifndef STREAMING_VITERBI_DECODER_DEFINES_SVH
`define STREAMING_VITERBI_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/svd_pkg.sv =====
package svd_pkg;

  localparam int DEPTH        = 64;
  localparam int SOFT_WIDTH   = 8;
  localparam int METRIC_WIDTH = 16;
  localparam int NUM_STATES   = 64;
  localparam int STATE_W      = 6;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int CAND_W       = METRIC_WIDTH + SOFT_WIDTH + 2;
  localparam int NUM_GROUPS   = 8;
  localparam int GROUP_SIZE   = NUM_STATES / NUM_GROUPS;

  localparam logic [6:0] GEN_FIRST  = 7'h6D;
  localparam logic [6:0] GEN_SECOND = 7'h4F;

  localparam logic [1:0] CMD_UPDATE  = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_FLUSH   = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [METRIC_WIDTH-1:0] METRIC_CAP = '1;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [7:0] soft_first;
    logic signed [7:0] soft_second;
    logic [5:0]        start_state;
  } item_t;

  typedef struct packed {
    logic decoded_bit;
    logic last_of_run;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACS,
    S_MIN1,
    S_MIN2,
    S_NORM,
    S_CHECK,
    S_TRACE,
    S_UPD_EMIT,
    S_FLUSH_EMIT
  } svd_state_t;

  typedef struct packed {
    logic                     init;
    logic [STATE_W-1:0]       init_state;
    logic                     acs_en;
    logic                     min1_en;
    logic                     min2_en;
    logic                     norm_en;
    logic signed [CAND_W-1:0] soft1;
    logic signed [CAND_W-1:0] soft2;
  } acs_ctrl_t;

  typedef struct packed {
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_slot;
    logic [NUM_STATES-1:0] wr_data;
    logic                  start;
    logic [SLOT_W-1:0]     start_slot;
    logic [CNT_W-1:0]      steps;
    logic [STATE_W-1:0]    start_state;
  } tb_ctrl_t;

  typedef struct packed {
    logic               step_valid;
    logic               step_bit;
    logic               done;
    logic [STATE_W-1:0] trace_state;
  } tb_stat_t;

  // Sign-extend the low SOFT_WIDTH bits of a soft input.
  function automatic logic signed [CAND_W-1:0] soft_ext(input logic [7:0] raw);
    logic signed [SOFT_WIDTH-1:0] v;
    v = raw[SOFT_WIDTH-1:0];
    return CAND_W'(v);
  endfunction

  // Cost of one branch: +soft where the coded bit is 1, -soft where it is 0.
  function automatic logic signed [CAND_W-1:0] branch_metric(
    input logic [6:0]               r,
    input logic signed [CAND_W-1:0] s1,
    input logic signed [CAND_W-1:0] s2
  );
    logic signed [CAND_W-1:0] a;
    logic signed [CAND_W-1:0] b;
    a = (^(r & GEN_FIRST)) ? s1 : -s1;
    b = (^(r & GEN_SECOND)) ? s2 : -s2;
    return a + b;
  endfunction

endpackage

// ===== src/svd_acs.sv =====
module svd_acs (
  input  logic                           clk,
  input  logic                           rst,
  input  svd_pkg::acs_ctrl_t             ctrl,
  output logic [svd_pkg::NUM_STATES-1:0] decisions,
  output logic [svd_pkg::STATE_W-1:0]    best
);
  import svd_pkg::*;

  logic [METRIC_WIDTH-1:0]  metric [NUM_STATES];
  logic [NUM_STATES-1:0]    reach;
  logic signed [CAND_W-1:0] cand [NUM_STATES];
  logic [NUM_STATES-1:0]    nreach;
  logic signed [CAND_W-1:0] g_min [NUM_GROUPS];
  logic [STATE_W-1:0]       g_idx [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]    g_val;
  logic signed [CAND_W-1:0] base;

  logic signed [CAND_W-1:0] cand_c [NUM_STATES];
  logic [NUM_STATES-1:0]    nreach_c;
  logic [NUM_STATES-1:0]    dec_c;
  logic signed [CAND_W-1:0] g_min_c [NUM_GROUPS];
  logic [STATE_W-1:0]       g_idx_c [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]    g_val_c;
  logic signed [CAND_W-1:0] base_c;
  logic [STATE_W-1:0]       best_c;
  logic                     base_val_c;
  logic [METRIC_WIDTH-1:0]  norm_c [NUM_STATES];

  // Add-compare-select for every next state; the first candidate wins ties.
  always_comb begin
    for (int nx = 0; nx < NUM_STATES; nx++) begin
      logic [STATE_W-1:0]       n6;
      logic [STATE_W-1:0]       p0;
      logic [STATE_W-1:0]       p1;
      logic signed [CAND_W-1:0] c0;
      logic signed [CAND_W-1:0] c1;
      logic                     pick1;
      n6 = STATE_W'(nx);
      p0 = {1'b0, n6[STATE_W-1:1]};
      p1 = {1'b1, n6[STATE_W-1:1]};
      c0 = $signed({{(CAND_W-METRIC_WIDTH){1'b0}}, metric[p0]})
           + branch_metric({1'b0, n6}, ctrl.soft1, ctrl.soft2);
      c1 = $signed({{(CAND_W-METRIC_WIDTH){1'b0}}, metric[p1]})
           + branch_metric({1'b1, n6}, ctrl.soft1, ctrl.soft2);
      pick1 = reach[p1] && (!reach[p0] || (c1 < c0));
      cand_c[nx] = pick1 ? c1 : c0;
      nreach_c[nx] = reach[p0] | reach[p1];
      dec_c[nx] = pick1;
    end
  end

  // First minimum level: lowest reachable candidate inside each group.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      g_min_c[g] = '0;
      g_idx_c[g] = '0;
      g_val_c[g] = 1'b0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (nreach[g*GROUP_SIZE+k] && (!g_val_c[g] || (cand[g*GROUP_SIZE+k] < g_min_c[g])))
        begin
          g_min_c[g] = cand[g*GROUP_SIZE+k];
          g_idx_c[g] = STATE_W'(g*GROUP_SIZE+k);
          g_val_c[g] = 1'b1;
        end
      end
    end
  end

  // Second level: lowest over the groups, lower index kept on a tie.
  always_comb begin
    base_c = '0;
    best_c = '0;
    base_val_c = 1'b0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g_val[g] && (!base_val_c || (g_min[g] < base_c))) begin
        base_c = g_min[g];
        best_c = g_idx[g];
        base_val_c = 1'b1;
      end
    end
  end

  // Renormalize to a zero minimum and saturate.
  always_comb begin
    for (int s = 0; s < NUM_STATES; s++) begin
      logic signed [CAND_W-1:0] d;
      d = cand[s] - base;
      if (!nreach[s]) begin
        norm_c[s] = '0;
      end else if (d > $signed({{(CAND_W-METRIC_WIDTH){1'b0}}, METRIC_CAP})) begin
        norm_c[s] = METRIC_CAP;
      end else begin
        norm_c[s] = d[METRIC_WIDTH-1:0];
      end
    end
  end

  // Metric and reachability registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metric[s] <= '0;
      end
      reach <= NUM_STATES'(1);
      best <= '0;
    end else if (ctrl.init) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metric[s] <= '0;
      end
      reach <= NUM_STATES'(1) << ctrl.init_state;
      best <= ctrl.init_state;
    end else if (ctrl.norm_en) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        metric[s] <= norm_c[s];
      end
      reach <= nreach;
      best <= best_c;
    end
  end

  // Intermediate pipeline registers of one update.
  always_ff @(posedge clk) begin
    if (ctrl.acs_en) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        cand[s] <= cand_c[s];
      end
      nreach <= nreach_c;
      decisions <= dec_c;
    end
    if (ctrl.min1_en) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        g_min[g] <= g_min_c[g];
        g_idx[g] <= g_idx_c[g];
      end
      g_val <= g_val_c;
    end
    if (ctrl.min2_en) begin
      base <= base_c;
    end
  end

endmodule

// ===== src/svd_traceback.sv =====
module svd_traceback (
  input  logic              clk,
  input  logic              rst,
  input  svd_pkg::tb_ctrl_t ctrl,
  output svd_pkg::tb_stat_t stat
);
  import svd_pkg::*;

  logic [NUM_STATES-1:0] ring [DEPTH];
  logic [NUM_STATES-1:0] rd_data;
  logic                  rd_valid;
  logic [SLOT_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      issue_left;
  logic [STATE_W-1:0]    st;
  logic                  done;

  function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] x);
    return (x == '0) ? SLOT_W'(DEPTH - 1) : x - 1'b1;
  endfunction

  // Survivor ring: one decision word written per update, one read per step.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      ring[ctrl.wr_slot] <= ctrl.wr_data;
    end
    if (issue_left != '0) begin
      rd_data <= ring[rd_addr];
    end
  end

  // Read sequencer walks the ring from the newest slot backwards.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      issue_left <= '0;
      done <= 1'b0;
    end else begin
      rd_valid <= (issue_left != '0);
      done <= rd_valid && (issue_left == '0);
      if (ctrl.start) begin
        rd_addr <= prev_slot(ctrl.start_slot);
        issue_left <= ctrl.steps;
      end else if (issue_left != '0) begin
        rd_addr <= prev_slot(rd_addr);
        issue_left <= issue_left - 1'b1;
      end
    end
  end

  // Trace state: shift in the predecessor's high bit from the decision word.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      st <= ctrl.start_state;
    end else if (rd_valid) begin
      st <= {rd_data[st], st[STATE_W-1:1]};
    end
  end

  assign stat.step_valid  = rd_valid;
  assign stat.step_bit    = st[0];
  assign stat.done        = done;
  assign stat.trace_state = st;

endmodule

// ===== src/streaming_viterbi_decoder.sv =====
// Hard-output Viterbi decoder, K=7 rate 1/2, generators 0x6D and 0x4F.
// Items enter on item_valid/item_ready and carry a command: update with a
// signed soft pair, restart at start_state, or flush. Result items leave on
// result_valid/result_ready, one decoded bit each, with last_of_run on the
// final bit that an item causes.
// An update steps through add-compare-select, two levels of minimum search,
// renormalization and a check. Once DEPTH steps are pending it also traces
// back DEPTH-1 steps, one survivor ring read per cycle, and emits one bit.
// A flush of n pending bits traces back n steps and then emits n bits,
// oldest first. Restart and the unused command complete in the idle state.
// The block works on one item at a time, but accepts the next item while
// its last result still waits in the output register; a stalled receiver
// holds the block only when a new result must be loaded.
// Reset makes state zero the only reachable state and empties the pending
// window; the survivor ring is not cleared and is only read where written.
`include "streaming_viterbi_decoder_defines.svh"

module streaming_viterbi_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  svd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output svd_pkg::result_t result
);
  import svd_pkg::*;

  svd_state_t               state;
  svd_state_t               state_next;
  logic [SLOT_W-1:0]        write_slot;
  logic [CNT_W-1:0]         pending;
  logic [CNT_W-1:0]         pending_inc;
  logic [CNT_W-1:0]         emit_left;
  logic                     is_flush;
  logic [DEPTH-1:0]         flush_bits;
  logic                     accept;
  logic                     out_free;
  logic                     load_out;
  logic signed [CAND_W-1:0] soft1;
  logic signed [CAND_W-1:0] soft2;
  acs_ctrl_t                acs_ctrl;
  tb_ctrl_t                 tb_ctrl;
  tb_stat_t                 tb_stat;
  logic [NUM_STATES-1:0]    decisions;
  logic [STATE_W-1:0]       best;

  svd_acs u_acs (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acs_ctrl),
    .decisions (decisions),
    .best      (best)
  );

  svd_traceback u_tb (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tb_ctrl),
    .stat (tb_stat)
  );

  assign accept      = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign pending_inc = (pending == CNT_W'(DEPTH)) ? pending : pending + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (item.command)
            CMD_UPDATE: state_next = S_ACS;
            CMD_FLUSH:  state_next = (pending != '0) ? S_TRACE : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ACS:   state_next = S_MIN1;
      S_MIN1:  state_next = S_MIN2;
      S_MIN2:  state_next = S_NORM;
      S_NORM:  state_next = S_CHECK;
      S_CHECK: state_next = (pending == CNT_W'(DEPTH)) ? S_TRACE : S_IDLE;
      S_TRACE: begin
        if (tb_stat.done) begin
          state_next = is_flush ? S_FLUSH_EMIT : S_UPD_EMIT;
        end
      end
      S_UPD_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_FLUSH_EMIT: begin
        if (out_free && (emit_left == CNT_W'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    item_ready = (state == S_IDLE);
    load_out = ((state == S_UPD_EMIT) || (state == S_FLUSH_EMIT)) && out_free;

    acs_ctrl.init       = accept && (item.command == CMD_RESTART);
    acs_ctrl.init_state = item.start_state;
    acs_ctrl.acs_en     = (state == S_ACS);
    acs_ctrl.min1_en    = (state == S_MIN1);
    acs_ctrl.min2_en    = (state == S_MIN2);
    acs_ctrl.norm_en    = (state == S_NORM);
    acs_ctrl.soft1      = soft1;
    acs_ctrl.soft2      = soft2;

    tb_ctrl.wr_en       = (state == S_NORM);
    tb_ctrl.wr_slot     = write_slot;
    tb_ctrl.wr_data     = decisions;
    tb_ctrl.start_slot  = write_slot;
    tb_ctrl.start_state = best;
    if (state == S_CHECK) begin
      tb_ctrl.start = (pending == CNT_W'(DEPTH));
      tb_ctrl.steps = CNT_W'(DEPTH - 1);
    end else begin
      tb_ctrl.start = accept && (item.command == CMD_FLUSH) && (pending != '0);
      tb_ctrl.steps = pending;
    end
  end

  // Hold the soft pair of the accepted item for the add-compare-select step.
  always_ff @(posedge clk) begin
    if (accept) begin
      soft1 <= soft_ext(item.soft_first);
      soft2 <= soft_ext(item.soft_second);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0;
      pending <= '0;
      emit_left <= '0;
      is_flush <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acs_ctrl.init) begin
        write_slot <= '0;
        pending <= '0;
      end else if (state == S_NORM) begin
        write_slot <= (write_slot == SLOT_W'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
        pending <= pending_inc;
      end else if (tb_ctrl.start && (state == S_CHECK)) begin
        pending <= CNT_W'(DEPTH - 1);
      end else if (tb_ctrl.start) begin
        pending <= '0;
        emit_left <= pending;
      end else if (load_out && (state == S_FLUSH_EMIT)) begin
        emit_left <= emit_left - 1'b1;
      end
      if (tb_ctrl.start) begin
        is_flush <= (state == S_IDLE);
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Traced bits arrive newest first; emit from the bottom, oldest first.
  always_ff @(posedge clk) begin
    if (tb_stat.step_valid) begin
      flush_bits <= {flush_bits[DEPTH-2:0], tb_stat.step_bit};
    end else if (load_out && (state == S_FLUSH_EMIT)) begin
      flush_bits <= {1'b0, flush_bits[DEPTH-1:1]};
    end
  end

  // Output item register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_FLUSH_EMIT) begin
        result.decoded_bit <= flush_bits[0];
        result.last_of_run <= (emit_left == CNT_W'(1));
      end else begin
        result.decoded_bit <= tb_stat.trace_state[0];
        result.last_of_run <= 1'b1;
      end
    end
  end

  `SVD_ASSERT_NOW(a_done_in_trace, tb_stat.done, state == S_TRACE, "traceback done outside trace")
  `SVD_ASSERT_NOW(a_upd_pending, state == S_UPD_EMIT, pending == CNT_W'(DEPTH - 1), "bad pending")
  `SVD_ASSERT_NOW(a_flush_left, state == S_FLUSH_EMIT, emit_left != '0 && pending == '0, "bad flush")
  `SVD_ASSERT_NEXT(a_upd_start, accept && item.command == CMD_UPDATE, state == S_ACS, "no ACS")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import svd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 120;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  streaming_viterbi_decoder dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  // Decoder state as the testbench tracks it.
  int          trellis_metric [NUM_STATES];
  bit          state_live [NUM_STATES];
  logic [63:0] decision_ring [DEPTH];
  int          ring_slot;
  int          window_fill;

  result_t expected_bits [$];
  int      mismatch_count;
  int      cycle_count;
  bit      idle_enable;
  int      rx_hold_cycles;
  int      rx_burst;
  logic [5:0] encoder_state;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int best_live_state();
    int best;
    bit found;
    best = 0;
    found = 0;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (state_live[s] && (!found || trellis_metric[s] < trellis_metric[best])) begin
        best = s;
        found = 1;
      end
    end
    return best;
  endfunction

  function automatic logic [5:0] trace_one(logic [5:0] st, int back);
    int slot;
    slot = (ring_slot + DEPTH - 1 - back) % DEPTH;
    return {decision_ring[slot][st], st[5:1]};
  endfunction

  // Advance the tracked decoder by one item and queue the bits it must emit.
  function automatic void predict_decoder(item_t it);
    int          cand [NUM_STATES];
    bit          nlive [NUM_STATES];
    logic [63:0] choice;
    logic [6:0]  shreg;
    logic [5:0]  prev;
    logic [5:0]  st;
    int          s1;
    int          s2;
    int          c;
    int          base;
    int          n;
    bit          any;
    result_t     burst [DEPTH];
    case (it.command)
      CMD_UPDATE: begin
        s1 = it.soft_first;
        s2 = it.soft_second;
        choice = '0;
        for (int nx = 0; nx < NUM_STATES; nx++) begin
          nlive[nx] = 0;
          cand[nx] = 0;
          for (int hb = 0; hb < 2; hb++) begin
            prev = 6'((nx >> 1) | (hb << 5));
            shreg = {prev, nx[0]};
            if (state_live[prev]) begin
              c = trellis_metric[prev] + ((^(shreg & GEN_FIRST)) ? s1 : -s1)
                  + ((^(shreg & GEN_SECOND)) ? s2 : -s2);
              if (!nlive[nx] || c < cand[nx]) begin
                cand[nx] = c;
                nlive[nx] = 1;
                choice[nx] = hb[0];
              end
            end
          end
        end
        base = 0;
        any = 0;
        for (int s = 0; s < NUM_STATES; s++) begin
          if (nlive[s] && (!any || cand[s] < base)) begin
            base = cand[s];
            any = 1;
          end
        end
        for (int s = 0; s < NUM_STATES; s++) begin
          state_live[s] = nlive[s];
          trellis_metric[s] = !nlive[s] ? 0 :
            ((cand[s] - base) > int'(METRIC_CAP) ? int'(METRIC_CAP) : cand[s] - base);
        end
        decision_ring[ring_slot] = choice;
        ring_slot = (ring_slot + 1) % DEPTH;
        if (window_fill < DEPTH) window_fill++;
        if (window_fill == DEPTH) begin
          st = 6'(best_live_state());
          for (int back = 0; back < DEPTH - 1; back++) st = trace_one(st, back);
          expected_bits.push_back('{decoded_bit: st[0], last_of_run: 1'b1});
          window_fill = DEPTH - 1;
        end
      end
      CMD_RESTART: begin
        for (int s = 0; s < NUM_STATES; s++) begin
          trellis_metric[s] = 0;
          state_live[s] = (s == it.start_state);
        end
        ring_slot = 0;
        window_fill = 0;
      end
      CMD_FLUSH: begin
        n = window_fill;
        if (n > 0) begin
          st = 6'(best_live_state());
          for (int back = 0; back < n; back++) begin
            burst[n - 1 - back] = '{decoded_bit: st[0], last_of_run: (back == 0)};
            st = trace_one(st, back);
          end
          for (int k = 0; k < n; k++) expected_bits.push_back(burst[k]);
          window_fill = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item, holding it until the decoder takes it.
  task automatic send_item(item_t it);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_decoder(it);
    @(negedge clk);
  endtask

  function automatic item_t make_item(logic [1:0] cmd, logic [7:0] a, logic [7:0] b,
                                      logic [5:0] ss);
    item_t it;
    it.command = cmd;
    it.soft_first = a;
    it.soft_second = b;
    it.start_state = ss;
    return it;
  endfunction

  // Soft pair for one encoded bit with random confidence and noise.
  function automatic item_t encoded_update();
    logic [6:0] shreg;
    int         mag;
    int         v1;
    int         v2;
    shreg = {encoder_state, 1'($urandom_range(0, 1))};
    encoder_state = shreg[5:0];
    mag = $urandom_range(10, 127);
    v1 = (^(shreg & GEN_FIRST)) ? -mag : mag;
    v2 = (^(shreg & GEN_SECOND)) ? -mag : mag;
    v1 = v1 + $signed($urandom_range(0, 120)) - 60;
    v2 = v2 + $signed($urandom_range(0, 120)) - 60;
    if (v1 > 127) v1 = 127;
    if (v1 < -128) v1 = -128;
    if (v2 > 127) v2 = 127;
    if (v2 < -128) v2 = -128;
    return make_item(CMD_UPDATE, 8'(v1), 8'(v2), 6'($urandom));
  endfunction

  task automatic wait_drained();
    wait (expected_bits.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Extremes of the soft values, each command, empty flush and the unused code.
  task automatic test_directed();
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_UNUSED, 8'h7F, 8'h80, 6'd63));
    send_item(make_item(CMD_UPDATE, 8'h7F, 8'h7F, 6'd0));
    send_item(make_item(CMD_UPDATE, 8'h80, 8'h80, 6'd63));
    send_item(make_item(CMD_UPDATE, 8'h7F, 8'h80, 6'd0));
    send_item(make_item(CMD_UPDATE, 8'h80, 8'h7F, 6'd0));
    send_item(make_item(CMD_UPDATE, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_UPDATE, 8'h55, 8'hAA, 6'd0));
    send_item(make_item(CMD_FLUSH, 8'hFF, 8'hFF, 6'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_RESTART, 8'h00, 8'h00, 6'd63));
    send_item(make_item(CMD_UPDATE, 8'h01, 8'hFF, 6'd0));
    send_item(make_item(CMD_UPDATE, 8'hAA, 8'h55, 6'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_RESTART, 8'h00, 8'h00, 6'd42));
    send_item(make_item(CMD_UPDATE, 8'h80, 8'h00, 6'd21));
    send_item(make_item(CMD_RESTART, 8'h00, 8'h00, 6'd21));
    send_item(make_item(CMD_UPDATE, 8'h00, 8'h7F, 6'd0));
    send_item(make_item(CMD_UNUSED, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    send_item(make_item(CMD_RESTART, 8'h00, 8'h00, 6'd0));
    encoder_state = '0;
  endtask

  // Mostly clean encoded streams, some raw noise, rare flush and restart.
  task automatic test_random(int count);
    int pick;
    item_t it;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        it = make_item(CMD_RESTART, 8'($urandom), 8'($urandom), 6'($urandom));
        encoder_state = it.start_state;
      end else if (pick < 4) begin
        it = make_item(CMD_FLUSH, 8'($urandom), 8'($urandom), 6'($urandom));
      end else if (pick < 5) begin
        it = make_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 6'($urandom));
      end else if (pick < 15) begin
        it = make_item(CMD_UPDATE, 8'($urandom), 8'($urandom), 6'($urandom));
      end else begin
        it = encoded_update();
      end
      send_item(it);
    end
  endtask

  // Receiver holds off while updates keep coming, then a flush, more updates and a full drain.
  task automatic test_backpressure();
    rx_hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_item(encoded_update());
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    for (int i = 0; i < 3; i++) send_item(encoded_update());
    item_valid = 1'b0;
    wait_drained();
  endtask

  // Receiver: long hold-offs on request, short random bursts otherwise.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      result_ready <= 1'b0;
    end else if (rx_burst > 0) begin
      rx_burst <= rx_burst - 1;
      result_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      rx_burst <= $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Compare each delivered bit with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_bits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result item: bit %0d last %0d",
                   result.decoded_bit, result.last_of_run);
      end else begin
        if (result !== expected_bits[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected bit %0d last %0d, got bit %0d last %0d",
                     expected_bits[0].decoded_bit, expected_bits[0].last_of_run,
                     result.decoded_bit, result.last_of_run);
        end
        void'(expected_bits.pop_front());
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    rx_hold_cycles = 0;
    rx_burst = 0;
    encoder_state = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      trellis_metric[s] = 0;
      state_live[s] = (s == 0);
    end
    for (int k = 0; k < DEPTH; k++) decision_ring[k] = '0;
    ring_slot = 0;
    window_fill = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(40);
    test_backpressure();
    test_random(30);
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    idle_enable = 1'b0;
    test_random(30);
    send_item(make_item(CMD_FLUSH, 8'h00, 8'h00, 6'd0));
    item_valid = 1'b0;
    wait_drained();

    if (mismatch_count == 0 && expected_bits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/svd_pkg.sv
src/svd_acs.sv
src/svd_traceback.sv
src/streaming_viterbi_decoder.sv
sim/tb.sv
